@@ rtl/core/swseg_pkg.sv @@
// ----------------------------------------------------------------------------
// Sweep object segmenter package
// Widths, constants, register indexes and the control and status types
// shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package swseg_pkg;

    localparam int ANGLE_W   = 8;
    localparam int RAW_W     = 12;
    localparam int DIST_W    = 16;
    localparam int CNT_W     = 8;
    localparam int ASUM_W    = 16;
    localparam int DSUM_W    = 24;
    localparam int OBJ_W     = 7;
    localparam int SPAN_W    = 8;
    localparam int STEP_W    = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int DIV_W     = 24;
    localparam int DVSR_W    = 17;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int K_W       = 27;
    localparam int PROD1_W   = SPAN_W + DIST_W;
    localparam int PROD2_W   = PROD1_W + K_W;

    localparam logic [DIV_W-1:0]  DIST_NUM_BASE   = 24'd8988000;
    localparam logic [DVSR_W-1:0] DIST_DEN_MUL    = 17'd25;
    localparam logic [DIV_W-1:0]  DIST_RAW_MUL    = 24'd68;
    localparam logic [K_W-1:0]    PI_OVER_180_Q32 = 27'd74961321;

    localparam logic [CFG_W-1:0]  MAX_RANGE_RST   = 16'd1040;
    localparam logic [CFG_W-1:0]  JUMP_THR_RST    = 16'd48;
    localparam logic [SPAN_W-1:0] MIN_SPAN_RST    = 8'd18;
    localparam logic [STEP_W-1:0] ANGLE_STEP_RST  = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_RANGE      = 2'd0,
        REG_JUMP_THRESHOLD = 2'd1,
        REG_MIN_SPAN       = 2'd2,
        REG_ANGLE_STEP     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_SEL_DIST,
        DIV_SEL_ANGLE_MEAN,
        DIV_SEL_DIST_MEAN
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     dist_store;
        logic     eval;
        logic     mean_a_store;
        logic     mean_d_store;
        logic     obj_update;
        logic     arc_sel_best;
        logic     arc_mul1;
        logic     arc_mul2;
        logic     emit_obj;
        logic     emit_best;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic report;
        logic final_smp;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic              kind;
        logic              found;
        logic [OBJ_W-1:0]  obj_num;
        logic [ANGLE_W-1:0] mean_angle;
        logic [DIST_W-1:0] mean_dist;
        logic [SPAN_W-1:0] span;
        logic [DIST_W-1:0] arc;
        logic              last;
    } t_result;

endpackage

@@ rtl/core/swseg_div.sv @@
// ----------------------------------------------------------------------------
// Sweep object segmenter divider
// Restoring divider, one quotient bit per cycle, shared by the distance
// conversion and the two run means.
// ----------------------------------------------------------------------------
module swseg_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [swseg_pkg::DIV_W-1:0]  i_dividend,
    input  logic [swseg_pkg::DVSR_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [swseg_pkg::DIV_W-1:0]  o_quotient
);
    import swseg_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVSR_W-1:0]    r_rem;
    logic [DVSR_W-1:0]    r_dvsr;
    logic [DIV_W-1:0]     r_quo;
    logic [DVSR_W:0]      w_shift;
    logic [DVSR_W:0]      w_sub;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_sub   = w_shift - {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvsr <= i_divisor;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            if (!w_sub[DVSR_W]) begin
                r_rem <= w_sub[DVSR_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DVSR_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/core/swseg_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sweep object segmenter controller
// Sequences distance conversion, run evaluation, the means, the arc
// multiply and the emission of object and best-object records.
// ----------------------------------------------------------------------------
module swseg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  swseg_pkg::t_status i_status,
    output swseg_pkg::t_cmd    o_cmd
);
    import swseg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST_GO,
        ST_DIST_WAIT,
        ST_EVAL,
        ST_MA_GO,
        ST_MA_WAIT,
        ST_MD_GO,
        ST_MD_WAIT,
        ST_OBJ,
        ST_ARC1,
        ST_ARC2,
        ST_EMIT_OBJ,
        ST_BARC1,
        ST_BARC2,
        ST_EMIT_BEST
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DIST_GO;
            end
            ST_DIST_GO:   n_state = ST_DIST_WAIT;
            ST_DIST_WAIT: begin
                if (i_status.div_done) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_status.report) begin
                    n_state = ST_MA_GO;
                end else if (i_status.final_smp) begin
                    n_state = ST_BARC1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MA_GO:   n_state = ST_MA_WAIT;
            ST_MA_WAIT: begin
                if (i_status.div_done) n_state = ST_MD_GO;
            end
            ST_MD_GO:   n_state = ST_MD_WAIT;
            ST_MD_WAIT: begin
                if (i_status.div_done) n_state = ST_OBJ;
            end
            ST_OBJ:  n_state = ST_ARC1;
            ST_ARC1: n_state = ST_ARC2;
            ST_ARC2: n_state = ST_EMIT_OBJ;
            ST_EMIT_OBJ: begin
                if (i_status.out_free) begin
                    n_state = i_status.final_smp ? ST_BARC1 : ST_IDLE;
                end
            end
            ST_BARC1: n_state = ST_BARC2;
            ST_BARC2: n_state = ST_EMIT_BEST;
            ST_EMIT_BEST: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_cmd = '0;
        w_cmd.div_sel = DIV_SEL_DIST;
        case (r_state)
            ST_IDLE:      w_cmd.load = i_in_valid;
            ST_DIST_GO:   w_cmd.div_start = 1'b1;
            ST_DIST_WAIT: w_cmd.dist_store = i_status.div_done;
            ST_EVAL:      w_cmd.eval = 1'b1;
            ST_MA_GO: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_SEL_ANGLE_MEAN;
            end
            ST_MA_WAIT:   w_cmd.mean_a_store = i_status.div_done;
            ST_MD_GO: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_SEL_DIST_MEAN;
            end
            ST_MD_WAIT:   w_cmd.mean_d_store = i_status.div_done;
            ST_OBJ:       w_cmd.obj_update = 1'b1;
            ST_ARC1:      w_cmd.arc_mul1 = 1'b1;
            ST_ARC2:      w_cmd.arc_mul2 = 1'b1;
            ST_EMIT_OBJ:  w_cmd.emit_obj = i_status.out_free;
            ST_BARC1: begin
                w_cmd.arc_mul1     = 1'b1;
                w_cmd.arc_sel_best = 1'b1;
            end
            ST_BARC2:     w_cmd.arc_mul2 = 1'b1;
            ST_EMIT_BEST: w_cmd.emit_best = i_status.out_free;
            default:      w_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd      = w_cmd;

endmodule

@@ rtl/core/swseg_dp.sv @@
// ----------------------------------------------------------------------------
// Sweep object segmenter datapath
// Configuration registers, sweep and run state, the shared divider, the
// arc multiplier and the output register.
// ----------------------------------------------------------------------------
module swseg_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [swseg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swseg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [swseg_pkg::ANGLE_W-1:0]   i_angle,
    input  logic [swseg_pkg::RAW_W-1:0]     i_ir_raw,
    input  logic                            i_first_sample,
    input  logic                            i_final_sample,
    input  swseg_pkg::t_cmd                 i_cmd,
    output swseg_pkg::t_status              o_status,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output swseg_pkg::t_result              o_result
);
    import swseg_pkg::*;

    localparam logic [PROD2_W:0] ROUND_HALF = (PROD2_W+1)'(64'd1 << 31);

    logic [CFG_W-1:0]   r_max_range;
    logic [CFG_W-1:0]   r_jump_thr;
    logic [SPAN_W-1:0]  r_min_span;
    logic [STEP_W-1:0]  r_angle_step;

    logic [ANGLE_W-1:0] r_angle;
    logic [RAW_W-1:0]   r_raw;
    logic               r_final;

    logic               r_run_started;
    logic [DIST_W-1:0]  r_ref;
    logic [CNT_W-1:0]   r_count;
    logic [ASUM_W-1:0]  r_asum;
    logic [DSUM_W-1:0]  r_dsum;
    logic [OBJ_W-1:0]   r_objects;
    logic [SPAN_W-1:0]  r_best_span;
    logic [ANGLE_W-1:0] r_best_angle;
    logic [DIST_W-1:0]  r_best_dist;

    logic [DIST_W-1:0]  r_dist;
    logic [SPAN_W-1:0]  r_span;
    logic [ANGLE_W-1:0] r_mean_a;
    logic [DIST_W-1:0]  r_mean_d;
    logic [PROD1_W-1:0] r_prod1;
    logic [PROD2_W-1:0] r_prod2;

    logic               r_out_valid;
    t_result            r_result;

    logic [DVSR_W-1:0]  w_den;
    logic [DIV_W-1:0]   w_num;
    logic [DIV_W-1:0]   w_dividend;
    logic [DVSR_W-1:0]  w_divisor;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_quo;

    logic               w_near;
    logic [DIST_W-1:0]  w_ref;
    logic [DIST_W-1:0]  w_diff;
    logic               w_jump;
    logic               w_acc;
    logic [CNT_W+STEP_W-1:0] w_span_full;
    logic [SPAN_W-1:0]  w_span;
    logic               w_report;

    logic [SPAN_W-1:0]  w_arc_span;
    logic [DIST_W-1:0]  w_arc_dist;
    logic [PROD2_W:0]   w_round;
    logic [PROD2_W-32:0] w_arc_full;
    logic [DIST_W-1:0]  w_arc;
    logic               w_out_free;

    // Distance numerator and divisor.
    assign w_den = DVSR_W'(r_raw) * DIST_DEN_MUL;
    assign w_num = DIST_NUM_BASE - DIV_W'(r_raw) * DIST_RAW_MUL
                 + DIV_W'(w_den >> 1);

    always_comb begin
        case (i_cmd.div_sel)
            DIV_SEL_DIST: begin
                w_dividend = w_num;
                w_divisor  = w_den;
            end
            DIV_SEL_ANGLE_MEAN: begin
                w_dividend = DIV_W'(r_asum);
                w_divisor  = DVSR_W'(r_count);
            end
            DIV_SEL_DIST_MEAN: begin
                w_dividend = r_dsum;
                w_divisor  = DVSR_W'(r_count);
            end
            default: begin
                w_dividend = w_num;
                w_divisor  = w_den;
            end
        endcase
    end

    swseg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Run evaluation of the current sample.
    assign w_near      = r_dist < r_max_range;
    assign w_ref       = r_run_started ? r_ref : r_dist;
    assign w_diff      = (r_dist >= w_ref) ? (r_dist - w_ref) : (w_ref - r_dist);
    assign w_jump      = w_near && (w_diff > r_jump_thr);
    assign w_acc       = w_near && !w_jump && (w_diff < r_jump_thr)
                       && (r_count != {CNT_W{1'b1}});
    assign w_span_full = (CNT_W+STEP_W)'(r_count) * (CNT_W+STEP_W)'(r_angle_step);
    assign w_span      = (|w_span_full[CNT_W+STEP_W-1:SPAN_W]) ? {SPAN_W{1'b1}}
                                                               : w_span_full[SPAN_W-1:0];
    assign w_report    = w_jump && (w_span > r_min_span) && (r_count != '0);

    // Arc width from span and distance.
    assign w_arc_span = i_cmd.arc_sel_best ? r_best_span : r_span;
    assign w_arc_dist = i_cmd.arc_sel_best ? r_best_dist : r_mean_d;
    assign w_round    = {1'b0, r_prod2} + ROUND_HALF;
    assign w_arc_full = w_round[PROD2_W:32];
    assign w_arc      = (|w_arc_full[PROD2_W-32:DIST_W]) ? {DIST_W{1'b1}}
                                                         : w_arc_full[DIST_W-1:0];

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range  <= MAX_RANGE_RST;
            r_jump_thr   <= JUMP_THR_RST;
            r_min_span   <= MIN_SPAN_RST;
            r_angle_step <= ANGLE_STEP_RST;
        end else if (i_cfg_wen) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MAX_RANGE:      r_max_range  <= i_cfg_data;
                REG_JUMP_THRESHOLD: r_jump_thr   <= i_cfg_data;
                REG_MIN_SPAN:       r_min_span   <= i_cfg_data[SPAN_W-1:0];
                REG_ANGLE_STEP:     r_angle_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_angle <= i_angle;
            r_raw   <= i_ir_raw;
            r_final <= i_final_sample;
        end
        if (i_cmd.dist_store) begin
            if (r_raw == '0 || (|w_quo[DIV_W-1:DIST_W])) begin
                r_dist <= {DIST_W{1'b1}};
            end else begin
                r_dist <= w_quo[DIST_W-1:0];
            end
        end
        if (i_cmd.eval) r_span <= w_span;
        if (i_cmd.mean_a_store) r_mean_a <= w_quo[ANGLE_W-1:0];
        if (i_cmd.mean_d_store) r_mean_d <= w_quo[DIST_W-1:0];
        if (i_cmd.arc_mul1) r_prod1 <= PROD1_W'(w_arc_span) * PROD1_W'(w_arc_dist);
        if (i_cmd.arc_mul2) r_prod2 <= PROD2_W'(r_prod1) * PROD2_W'(PI_OVER_180_Q32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.load && i_first_sample) || i_cmd.emit_best) begin
            r_run_started <= 1'b0;
            r_ref         <= '0;
            r_count       <= '0;
            r_asum        <= '0;
            r_dsum        <= '0;
            r_objects     <= '0;
            r_best_span   <= '0;
            r_best_angle  <= '0;
            r_best_dist   <= '0;
        end else if (i_cmd.eval) begin
            if (w_near) r_run_started <= 1'b1;
            if (w_near && (!r_run_started || w_jump)) r_ref <= r_dist;
            if (w_jump && !w_report) begin
                r_count <= '0;
                r_asum  <= '0;
                r_dsum  <= '0;
            end else if (w_acc) begin
                r_count <= r_count + 1'b1;
                r_asum  <= r_asum + ASUM_W'(r_angle);
                r_dsum  <= r_dsum + DSUM_W'(r_dist);
            end
        end else if (i_cmd.obj_update) begin
            if (r_objects != {OBJ_W{1'b1}}) r_objects <= r_objects + 1'b1;
            if (r_best_span < r_span) begin
                r_best_span  <= r_span;
                r_best_angle <= r_mean_a;
                r_best_dist  <= r_mean_d;
            end
            r_count <= '0;
            r_asum  <= '0;
            r_dsum  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_obj || i_cmd.emit_best) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_obj) begin
            r_result.kind       <= 1'b0;
            r_result.found      <= 1'b0;
            r_result.obj_num    <= r_objects;
            r_result.mean_angle <= r_mean_a;
            r_result.mean_dist  <= r_mean_d;
            r_result.span       <= r_span;
            r_result.arc        <= w_arc;
            r_result.last       <= !r_final;
        end else if (i_cmd.emit_best) begin
            r_result.kind       <= 1'b1;
            r_result.found      <= (r_objects != '0);
            r_result.obj_num    <= r_objects;
            r_result.mean_angle <= r_best_angle;
            r_result.mean_dist  <= r_best_dist;
            r_result.span       <= r_best_span;
            r_result.arc        <= w_arc;
            r_result.last       <= 1'b1;
        end
    end

    assign o_status.div_done  = w_div_done;
    assign o_status.report    = w_report;
    assign o_status.final_smp = r_final;
    assign o_status.out_free  = w_out_free;
    assign o_out_valid        = r_out_valid;
    assign o_result           = r_result;

endmodule

@@ rtl/core/sweep_object_segmenter_core.sv @@
// ----------------------------------------------------------------------------
// Sweep object segmenter core
// Converts IR sweep samples to distances, groups near samples into runs and
// reports each wide enough run as an object, plus a best-object record at
// the end of every sweep.
//
//   Channel   Direction  Carries
//   s_axis    in         one sweep sample per transfer
//   m_axis    out        object and best-object records
//   cfg       in         register writes, no wait and no read-back
//
// A sample passes through the 24-step shared divider for the distance
// conversion before the next is accepted. A sample that closes a reported run
// adds two more divider passes for the means and the two-stage arc multiply;
// the final sample adds the arc multiply and the best-object record.
// Reset is synchronous and active low and needs no clearing pass.
// A result waits in the output register while the next sample is accepted;
// processing stalls only when a second record must be emitted before the
// first was taken.
// ----------------------------------------------------------------------------
module sweep_object_segmenter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [23:0]                     i_s_axis_tdata,  // angle, ir_raw
    input  logic                            i_s_axis_tuser,  // first_sample
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // object_number, mean_angle, mean_distance, span_degrees, arc_width
    output logic [55:0]                     o_m_axis_tdata,
    output logic [1:0]                      o_m_axis_tuser,  // record_kind, found
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_wen,
    input  logic [swseg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swseg_pkg::CFG_W-1:0]     i_cfg_data
);
    import swseg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_result w_result;
    logic    w_out_valid;
    logic    w_in_ready;

    swseg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    swseg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_angle        (i_s_axis_tdata[ANGLE_W-1:0]),
        .i_ir_raw       (i_s_axis_tdata[ANGLE_W+RAW_W-1:ANGLE_W]),
        .i_first_sample (i_s_axis_tuser),
        .i_final_sample (i_s_axis_tlast),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (w_out_valid),
        .i_out_ready    (i_m_axis_tready),
        .o_result       (w_result)
    );

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tdata  = {1'b0, w_result.arc, w_result.span, w_result.mean_dist,
                              w_result.mean_angle, w_result.obj_num};
    assign o_m_axis_tuser  = {w_result.found, w_result.kind};
    assign o_m_axis_tlast  = w_result.last;

endmodule

@@ rtl/core/swseg_chk.sv @@
// ----------------------------------------------------------------------------
// Sweep object segmenter checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module swseg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled output transfer changed");

    a_best_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tlast)
        else $error("best-object record not marked last");

    a_found_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tuser[0])
        else $error("found flag on an object record");

    a_obj_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[6:0] != 7'd0)
        else $error("object record with object number zero");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after an accepted sample");

endmodule

bind sweep_object_segmenter_core swseg_chk u_swseg_chk (.*);
